FILE: src/bresenham_line_rasterizer_unit_defines.svh
// Assertion helpers shared by the rasterizer modules.
// Each expects signals named clk and arst_n in the calling module.
`ifndef BRESENHAM_LINE_RASTERIZER_UNIT_DEFINES_SVH
`define BRESENHAM_LINE_RASTERIZER_UNIT_DEFINES_SVH

// same-cycle implication
`define BRL_ASSERT_IMP(name, ante, cons) \
	name: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("rasterizer check failed");

// next-cycle implication
`define BRL_ASSERT_NEXT(name, ante, cons) \
	name: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("rasterizer check failed");

`endif

FILE: src/brl_pkg.sv
package brl_pkg;

	// fixed field widths
	localparam int COORD_W = 6;
	localparam int COLOR_W = 32;

	// input word layout, lowest bit first
	localparam int START_X_LSB = 0;
	localparam int START_Y_LSB = START_X_LSB + COORD_W;
	localparam int END_X_LSB   = START_Y_LSB + COORD_W;
	localparam int END_Y_LSB   = END_X_LSB + COORD_W;
	localparam int COLOR_LSB   = END_Y_LSB + COORD_W;
	localparam int IN_BITS     = COLOR_LSB + COLOR_W;
	localparam int IN_DATA_W   = ((IN_BITS + 7) / 8) * 8;

	// output word layout, lowest bit first
	localparam int PIX_X_LSB     = 0;
	localparam int PIX_Y_LSB     = PIX_X_LSB + COORD_W;
	localparam int PIX_COLOR_LSB = PIX_Y_LSB + COORD_W;
	localparam int OUT_BITS      = PIX_COLOR_LSB + COLOR_W;
	localparam int OUT_DATA_W    = ((OUT_BITS + 7) / 8) * 8;

	// controller to datapath
	typedef struct packed {
		logic load;  // latch a new line command and set up the walk
		logic step;  // emit current pixel and advance one major step
	} brl_cmd_t;

	// datapath to controller
	typedef struct packed {
		logic slot_free;  // output register can take a pixel this cycle
		logic at_end;     // current major coordinate is the end point
	} brl_sts_t;

endpackage

FILE: src/brl_dp.sv
module brl_dp #(
	parameter int CB = 6
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic [brl_pkg::IN_DATA_W-1:0] in_data,
	input  brl_pkg::brl_cmd_t             cmd,
	output brl_pkg::brl_sts_t             sts,
	input  logic                          out_ready,
	output logic                          out_valid,
	output logic [brl_pkg::OUT_DATA_W-1:0] out_data,
	output logic                          out_last
);
	import brl_pkg::*;

	`include "bresenham_line_rasterizer_unit_defines.svh"

	localparam int EW = CB + 3;

	// setup signals
	logic [CB-1:0] ax, ay, bx, by, adx, ady;
	logic [CB-1:0] sa_maj, sa_min, sb_maj, sb_min;
	logic [CB-1:0] ma, mia, mb, mib, dmaj, dmin;
	logic          steep;
	logic signed [EW-1:0] inc_flat_d, inc_step_d, err_d;

	// walk state
	logic [CB-1:0]        major_q, minor_q, end_q;
	logic signed [EW-1:0] err_q, inc_flat_q, inc_step_q;
	logic                 up_q, steep_q;
	logic [COLOR_W-1:0]   color_q;

	// output register
	logic                 out_valid_q, out_last_q;
	logic [COORD_W-1:0]   out_x_q, out_y_q;
	logic [COLOR_W-1:0]   out_color_q;
	logic [CB-1:0]        px, py;

	// setup: mask, swap axes if steep, order by major coordinate
	always_comb begin
		ax = in_data[START_X_LSB +: CB];
		ay = in_data[START_Y_LSB +: CB];
		bx = in_data[END_X_LSB +: CB];
		by = in_data[END_Y_LSB +: CB];
		adx = (ax > bx) ? ax - bx : bx - ax;
		ady = (ay > by) ? ay - by : by - ay;
		steep = adx < ady;
		sa_maj = steep ? ay : ax;
		sa_min = steep ? ax : ay;
		sb_maj = steep ? by : bx;
		sb_min = steep ? bx : by;
		if (sa_maj > sb_maj) begin
			ma  = sb_maj;
			mia = sb_min;
			mb  = sa_maj;
			mib = sa_min;
		end else begin
			ma  = sa_maj;
			mia = sa_min;
			mb  = sb_maj;
			mib = sb_min;
		end
		dmaj = mb - ma;
		dmin = (mib > mia) ? mib - mia : mia - mib;
		inc_flat_d = $signed({2'b00, dmin, 1'b0});
		inc_step_d = inc_flat_d - $signed({2'b00, dmaj, 1'b0});
		err_d      = inc_flat_d - $signed({3'b000, dmaj});
	end

	// pixel coordinates, swapped back for steep lines
	assign px = steep_q ? minor_q : major_q;
	assign py = steep_q ? major_q : minor_q;

	// walk registers
	always_ff @(posedge clk) begin
		if (cmd.load) begin
			major_q    <= ma;
			minor_q    <= mia;
			end_q      <= mb;
			err_q      <= err_d;
			inc_flat_q <= inc_flat_d;
			inc_step_q <= inc_step_d;
			up_q       <= mia < mib;
			steep_q    <= steep;
			color_q    <= in_data[COLOR_LSB +: COLOR_W];
		end else if (cmd.step) begin
			major_q <= major_q + 1'b1;
			if (err_q[EW-1]) begin
				err_q <= err_q + inc_flat_q;
			end else begin
				err_q   <= err_q + inc_step_q;
				minor_q <= up_q ? minor_q + 1'b1 : minor_q - 1'b1;
			end
		end
	end

	// output register payload
	always_ff @(posedge clk) begin
		if (cmd.step) begin
			out_x_q     <= COORD_W'(px);
			out_y_q     <= COORD_W'(py);
			out_color_q <= color_q;
			out_last_q  <= major_q == end_q;
		end
	end

	// output register valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (cmd.step) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	assign sts.slot_free = !out_valid_q || out_ready;
	assign sts.at_end    = major_q == end_q;

	assign out_valid = out_valid_q;
	assign out_last  = out_last_q;
	assign out_data  = OUT_DATA_W'({out_color_q, out_y_q, out_x_q});

	`BRL_ASSERT_NEXT(a_last_marked, cmd.step && sts.at_end, out_valid_q && out_last_q)
	`BRL_ASSERT_NEXT(a_major_adv, cmd.step && !sts.at_end, major_q == $past(major_q) + 1'b1)
	`BRL_ASSERT_IMP(a_no_overrun, cmd.step, sts.slot_free)

endmodule

FILE: src/brl_ctrl.sv
module brl_ctrl (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              in_valid,
	output logic              in_ready,
	input  brl_pkg::brl_sts_t sts,
	output brl_pkg::brl_cmd_t cmd
);
	import brl_pkg::*;

	`include "bresenham_line_rasterizer_unit_defines.svh"

	typedef enum logic {
		ST_IDLE,
		ST_RUN
	} state_t;

	state_t state_q;
	logic   rdy_q;

	// commands
	assign cmd.load = in_valid && rdy_q;
	assign cmd.step = (state_q == ST_RUN) && sts.slot_free;
	assign in_ready = rdy_q;

	// state and registered ready
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			rdy_q   <= 1'b1;
		end else begin
			case (state_q)
				ST_IDLE: begin
					if (cmd.load) begin
						state_q <= ST_RUN;
						rdy_q   <= 1'b0;
					end
				end
				ST_RUN: begin
					if (cmd.step && sts.at_end) begin
						state_q <= ST_IDLE;
						rdy_q   <= 1'b1;
					end
				end
				default: begin
					state_q <= ST_IDLE;
					rdy_q   <= 1'b1;
				end
			endcase
		end
	end

	`BRL_ASSERT_NEXT(a_load_busy, cmd.load, !rdy_q && state_q == ST_RUN)
	`BRL_ASSERT_IMP(a_ready_idle, rdy_q, state_q == ST_IDLE)
	`BRL_ASSERT_NEXT(a_end_idle, cmd.step && sts.at_end, rdy_q)

endmodule

FILE: src/bresenham_line_rasterizer_unit.sv
// Line rasterizer for a 2^COORD_BITS square tile. Each input word is one line
// command (two endpoints and a color); the block answers with one output word
// per pixel, in rising order of the major axis, with tlast on the final pixel.
// Coordinates are masked to their low COORD_BITS bits. Commands are handled
// one at a time: the setup is done in the accepting cycle, then a line of n
// pixels (n = max(|dx|, |dy|) + 1, up to 2^COORD_BITS) keeps s_tready low
// until its last pixel has been stepped, one pixel per cycle from the
// stepping loop while the output side does not stall. A one-word output
// register sits on the master side, so the next command can be taken while
// the last pixel still waits.
module bresenham_line_rasterizer_unit #(
	parameter int COORD_BITS = 6
) (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           s_tvalid,
	output logic                           s_tready,
	// start_x, start_y, end_x, end_y, line_color
	input  logic [brl_pkg::IN_DATA_W-1:0]  s_tdata,
	output logic                           m_tvalid,
	input  logic                           m_tready,
	// pixel_x, pixel_y, pixel_color, zero fill
	output logic [brl_pkg::OUT_DATA_W-1:0] m_tdata,
	output logic                           m_tlast
);
	import brl_pkg::*;

	brl_cmd_t cmd;
	brl_sts_t sts;

	brl_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (s_tvalid),
		.in_ready (s_tready),
		.sts      (sts),
		.cmd      (cmd)
	);

	brl_dp #(
		.CB (COORD_BITS)
	) u_dp (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_data   (s_tdata),
		.cmd       (cmd),
		.sts       (sts),
		.out_ready (m_tready),
		.out_valid (m_tvalid),
		.out_data  (m_tdata),
		.out_last  (m_tlast)
	);

endmodule
